### hw/rtl/overwriting_trace_ring_assert.svh
// Assertion macros used by the trace ring controller.
`ifndef OVERWRITING_TRACE_RING_ASSERT_SVH
`define OVERWRITING_TRACE_RING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTR_ASSERT_NOW(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("trace ring assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OTR_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("trace ring assertion failed");

`endif

### hw/rtl/otr_pkg.sv
package otr_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_FETCH  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  event_id;
    logic [7:0]  event_arg;
    logic [31:0] timestamp;
  } cmd_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] entry_time;
    logic [7:0]  entry_id;
    logic [7:0]  entry_arg;
    logic [8:0]  pending_count;
    logic [31:0] dropped_count;
  } result_t;

  typedef struct packed {
    logic [31:0] tstamp;
    logic [7:0]  id;
    logic [7:0]  arg;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

  typedef struct packed {
    logic        strobe;
    logic        hit;
    logic [8:0]  pending;
    logic [31:0] dropped;
  } status_t;

endpackage

### hw/rtl/otr_store.sv
module otr_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  otr_pkg::mem_ctl_t mem_ctl,
  input  logic [AW-1:0]    addr,
  input  otr_pkg::entry_t  wdata,
  output otr_pkg::entry_t  rdata
);
  import otr_pkg::*;

  entry_t mem [DEPTH];

  // Single port: at most one of write and read is requested in a cycle.
  always_ff @(posedge clk) begin
    if (mem_ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (mem_ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hw/rtl/otr_ctrl.sv
`include "overwriting_trace_ring_assert.svh"

module otr_ctrl #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  otr_pkg::cmd_t     cmd,
  output logic              busy,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output otr_pkg::mem_ctl_t mem_ctl,
  output logic [AW-1:0]     mem_addr,
  output otr_pkg::entry_t   mem_wdata,
  output otr_pkg::status_t  status
);
  import otr_pkg::*;

  localparam logic [AW-1:0] LAST      = AW'(DEPTH - 1);
  localparam logic [31:0]   DEPTH32   = 32'(DEPTH);
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(DEPTH);
  // Slot of the count 2^32, i.e. where a count lands after wrapping past zero.
  localparam logic [AW-1:0] WRAP_REM  = AW'((64'd1 << 32) % 64'(DEPTH));

  logic          enable;
  logic [31:0]   wr_count;
  logic [31:0]   rd_count;
  logic [31:0]   drop_total;
  logic [AW-1:0] wr_slot;
  logic [AW-1:0] rd_slot;
  logic          strobe;
  logic          hit;

  logic          accept;
  logic [31:0]   avail;
  logic          lapped;
  logic          wr_ge_depth;
  logic [AW:0]   wrap_sum;
  logic [AW-1:0] wrap_slot;
  logic [31:0]   pos;
  logic [AW-1:0] pos_slot;
  logic [AW-1:0] wr_slot_inc;
  logic [AW-1:0] pos_slot_inc;
  logic          is_rec;
  logic          is_fetch;
  logic          is_clear;

  // One memory access per item, so an item can enter every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign accept = start && !busy;
  assign avail  = wr_count - rd_count;
  assign lapped = avail > DEPTH32;

  // When lapped the oldest surviving entry sits at write_count - DEPTH. Its
  // slot equals the write slot unless that subtraction wraps below zero.
  assign wr_ge_depth = wr_count >= DEPTH32;
  assign wrap_sum    = {1'b0, WRAP_REM} + {1'b0, wr_slot};
  assign wrap_slot   = (wrap_sum >= DEPTH_EXT) ? AW'(wrap_sum - DEPTH_EXT) : wrap_sum[AW-1:0];

  assign pos      = lapped ? (wr_count - DEPTH32) : rd_count;
  assign pos_slot = lapped ? (wr_ge_depth ? wr_slot : wrap_slot) : rd_slot;

  // Slots follow the counts modulo the depth, including the wrap at 2^32.
  assign wr_slot_inc  = (wr_count == '1 || wr_slot == LAST) ? '0 : wr_slot + 1'b1;
  assign pos_slot_inc = (pos == '1 || pos_slot == LAST) ? '0 : pos_slot + 1'b1;

  assign is_rec   = accept && cmd.kind == KIND_RECORD && enable;
  assign is_fetch = accept && cmd.kind == KIND_FETCH && avail != '0;
  assign is_clear = accept && cmd.kind == KIND_CLEAR;

  assign mem_ctl.wr       = is_rec;
  assign mem_ctl.rd       = is_fetch;
  assign mem_addr         = is_rec ? wr_slot : pos_slot;
  assign mem_wdata.tstamp = cmd.timestamp;
  assign mem_wdata.id     = cmd.event_id;
  assign mem_wdata.arg    = cmd.event_arg;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      wr_count   <= '0;
      rd_count   <= '0;
      drop_total <= '0;
      wr_slot    <= '0;
      rd_slot    <= '0;
      strobe     <= 1'b0;
      hit        <= 1'b0;
    end else begin
      strobe <= accept;
      hit    <= is_fetch;
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
      priority if (is_clear) begin
        wr_count   <= '0;
        rd_count   <= '0;
        drop_total <= '0;
        wr_slot    <= '0;
        rd_slot    <= '0;
      end else if (is_rec) begin
        wr_count <= wr_count + 32'd1;
        wr_slot  <= wr_slot_inc;
      end else if (is_fetch) begin
        if (lapped) begin
          drop_total <= drop_total + (avail - DEPTH32);
        end
        rd_count <= pos + 32'd1;
        rd_slot  <= pos_slot_inc;
      end
    end
  end

  // In the beat after an item the counters already hold its outcome.
  assign status.strobe  = strobe;
  assign status.hit     = hit;
  assign status.pending = lapped ? DEPTH32[8:0] : avail[8:0];
  assign status.dropped = drop_total;

  `OTR_ASSERT_NEXT(a_one_result, clk, rst, !rst && accept, strobe)
  `OTR_ASSERT_NOW(a_hit_in_result, clk, rst, hit, strobe)
  `OTR_ASSERT_NEXT(a_clear_zeroes, clk, rst, !rst && is_clear,
    wr_count == '0 && rd_count == '0 && drop_total == '0)
  `OTR_ASSERT_NEXT(a_disabled_record, clk, rst,
    !rst && accept && cmd.kind == KIND_RECORD && !enable, $stable(wr_count))

endmodule

### hw/rtl/overwriting_trace_ring.sv
// Event trace ring that overwrites its oldest entries and counts the losses.
// Latency: the result for an item is strobed in the cycle after it is accepted.
// Throughput: one item per cycle; busy stays low, as each item needs one access
// to the single-port entry memory.
// Reset clears the counts, the drop total and the recording enable; the entry
// memory is not cleared. Results cannot be stalled by the receiver.
module overwriting_trace_ring #(
  parameter int unsigned DEPTH = otr_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  otr_pkg::cmd_t    cmd,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  output logic             result_valid,
  output otr_pkg::result_t result
);
  import otr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  status_t       status;

  otr_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .status   (status)
  );

  otr_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .mem_ctl(mem_ctl),
    .addr   (mem_addr),
    .wdata  (mem_wdata),
    .rdata  (mem_rdata)
  );

  // Entry fields read as zero unless the beat carries a fetched entry.
  always_comb begin
    result_valid         = status.strobe;
    result.entry_valid   = status.hit;
    result.entry_time    = status.hit ? mem_rdata.tstamp : '0;
    result.entry_id      = status.hit ? mem_rdata.id : '0;
    result.entry_arg     = status.hit ? mem_rdata.arg : '0;
    result.pending_count = status.pending;
    result.dropped_count = status.dropped;
  end

endmodule

### sim/overwriting_trace_ring_tb.sv
`timescale 1ns / 1ps

module overwriting_trace_ring_tb;
  import otr_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEFAULT;
  localparam int unsigned RING_AW = $clog2(RING_DEPTH);
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Phase kinds of the random part.
  localparam int unsigned PH_MIXED = 0;
  localparam int unsigned PH_FLOOD = 1;
  localparam int unsigned PH_READOUT = 2;
  localparam int unsigned PH_MUTED = 3;

  typedef struct {
    bit      set_cfg;
    bit      enable;
    cmd_t    c;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data = 1'b0;
  logic    result_valid;
  result_t result;

  // Shadow copy of the ring state.
  logic        rec_en;
  logic [31:0] wr_cnt;
  logic [31:0] rd_cnt;
  logic [31:0] drop_sum;
  entry_t      ring_mem [RING_DEPTH];

  result_t     due_results [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned counted = 0;

  overwriting_trace_ring #(.DEPTH(RING_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("overwriting_trace_ring_tb: FAIL");
      $finish;
    end
  end

  function automatic result_t trace_ring_predict(cmd_t c);
    result_t            r;
    logic [31:0]        avail;
    logic [31:0]        pos;
    logic [31:0]        lost;
    logic [RING_AW-1:0] slot;
    r = '0;
    case (c.kind)
      KIND_RECORD: begin
        if (rec_en) begin
          slot = RING_AW'(wr_cnt % RING_DEPTH);
          ring_mem[slot] = '{tstamp: c.timestamp, id: c.event_id, arg: c.event_arg};
          wr_cnt = wr_cnt + 1;
        end
      end
      KIND_FETCH: begin
        avail = wr_cnt - rd_cnt;
        if (avail != 0) begin
          pos = rd_cnt;
          // A lapped reader skips to the oldest entry still held.
          if (avail > RING_DEPTH) begin
            lost = avail - RING_DEPTH;
            drop_sum = drop_sum + lost;
            pos = pos + lost;
          end
          slot = RING_AW'(pos % RING_DEPTH);
          r.entry_valid = 1'b1;
          r.entry_time = ring_mem[slot].tstamp;
          r.entry_id = ring_mem[slot].id;
          r.entry_arg = ring_mem[slot].arg;
          rd_cnt = pos + 1;
        end
      end
      KIND_CLEAR: begin
        wr_cnt = '0;
        rd_cnt = '0;
        drop_sum = '0;
      end
      default: ;
    endcase
    avail = wr_cnt - rd_cnt;
    pos = RING_DEPTH;
    r.pending_count = (avail > RING_DEPTH) ? pos[8:0] : avail[8:0];
    r.dropped_count = drop_sum;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (due_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("entry_valid", 32'(want.entry_valid), 32'(result.entry_valid));
        check_field("entry_time", want.entry_time, result.entry_time);
        check_field("entry_id", 32'(want.entry_id), 32'(result.entry_id));
        check_field("entry_arg", 32'(want.entry_arg), 32'(result.entry_arg));
        check_field("pending_count", 32'(want.pending_count),
                    32'(result.pending_count));
        check_field("dropped_count", want.dropped_count, result.dropped_count);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // start still high, so a following beat can go out back to back.
  task automatic drive_item(cmd_t c, bit typed, result_t want);
    result_t predicted;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    counted++;
    predicted = trace_ring_predict(c);
    due_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic idle(int unsigned n);
    cmd_t junk;
    junk = cmd_t'({$urandom, $urandom});
    start <= 1'b0;
    cmd <= junk;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_enable(logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    rec_en = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t row(bit set_cfg, bit enable, logic [1:0] kind,
                                    logic [7:0] id, logic [7:0] arg, logic [31:0] ts,
                                    bit typed, result_t want);
    plan_row_t r;
    r.set_cfg = set_cfg;
    r.enable = enable;
    r.c = '{kind: kind, event_id: id, event_arg: arg, timestamp: ts};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic cmd_t random_cmd(int unsigned rec_pct, int unsigned fetch_pct);
    cmd_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.event_id = 8'($urandom);
    c.event_arg = 8'($urandom);
    c.timestamp = $urandom;
    if (pick < rec_pct)
      c.kind = KIND_RECORD;
    else if (pick < rec_pct + fetch_pct)
      c.kind = KIND_FETCH;
    else if (pick < rec_pct + fetch_pct + (100 - rec_pct - fetch_pct) / 2)
      c.kind = KIND_CLEAR;
    else
      c.kind = KIND_UNUSED;
    return c;
  endfunction

  initial begin
    plan_row_t   plan [$];
    result_t     none;
    cmd_t        c;
    int unsigned phase;
    int unsigned mode;
    int unsigned n_items;
    int unsigned burst_left;
    bit          gappy;

    none = '0;
    rec_en = 1'b0;
    wr_cnt = '0;
    rd_cnt = '0;
    drop_sum = '0;

    // Recording is off after reset, so the first four beats change nothing.
    plan.push_back(row(0, 0, KIND_RECORD, 8'hff, 8'hff, 32'hffffffff, 1, none));
    plan.push_back(row(0, 0, KIND_FETCH, 8'h00, 8'h00, 32'h0, 1, none));
    plan.push_back(row(0, 0, KIND_UNUSED, 8'hff, 8'hff, 32'hffffffff, 1, none));
    plan.push_back(row(0, 0, KIND_CLEAR, 8'h00, 8'h00, 32'h0, 1, none));
    plan.push_back(row(1, 1, KIND_RECORD, 8'hff, 8'h00, 32'hffffffff, 1,
                       {1'b0, 32'h0, 8'h00, 8'h00, 9'd1, 32'd0}));
    plan.push_back(row(0, 0, KIND_RECORD, 8'h00, 8'hff, 32'h0, 1,
                       {1'b0, 32'h0, 8'h00, 8'h00, 9'd2, 32'd0}));
    plan.push_back(row(0, 0, KIND_RECORD, 8'h5a, 8'ha5, 32'h80000001, 1,
                       {1'b0, 32'h0, 8'h00, 8'h00, 9'd3, 32'd0}));
    plan.push_back(row(0, 0, KIND_FETCH, 8'h00, 8'h00, 32'h0, 1,
                       {1'b1, 32'hffffffff, 8'hff, 8'h00, 9'd2, 32'd0}));
    plan.push_back(row(0, 0, KIND_FETCH, 8'hff, 8'hff, 32'hffffffff, 1,
                       {1'b1, 32'h0, 8'h00, 8'hff, 9'd1, 32'd0}));
    plan.push_back(row(0, 0, KIND_UNUSED, 8'h00, 8'h00, 32'h0, 1,
                       {1'b0, 32'h0, 8'h00, 8'h00, 9'd1, 32'd0}));
    plan.push_back(row(1, 0, KIND_RECORD, 8'h11, 8'h22, 32'h33, 1,
                       {1'b0, 32'h0, 8'h00, 8'h00, 9'd1, 32'd0}));
    plan.push_back(row(0, 0, KIND_FETCH, 8'h00, 8'h00, 32'h0, 1,
                       {1'b1, 32'h80000001, 8'h5a, 8'ha5, 9'd0, 32'd0}));
    plan.push_back(row(0, 0, KIND_FETCH, 8'h00, 8'h00, 32'h0, 1, none));
    plan.push_back(row(1, 1, KIND_RECORD, 8'ha5, 8'h5a, 32'h7fffffff, 0, none));
    plan.push_back(row(0, 0, KIND_RECORD, 8'h3c, 8'hc3, 32'h00010000, 0, none));
    // Clearing keeps the stored entries but zeroes both counts and the drop total.
    plan.push_back(row(0, 0, KIND_CLEAR, 8'hff, 8'hff, 32'hffffffff, 1, none));
    plan.push_back(row(0, 0, KIND_FETCH, 8'h00, 8'h00, 32'h0, 1, none));
    plan.push_back(row(0, 0, KIND_RECORD, 8'h01, 8'h80, 32'h00000001, 1,
                       {1'b0, 32'h0, 8'h00, 8'h00, 9'd1, 32'd0}));
    plan.push_back(row(0, 0, KIND_FETCH, 8'h00, 8'h00, 32'h0, 1,
                       {1'b1, 32'h00000001, 8'h01, 8'h80, 9'd0, 32'd0}));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].set_cfg) begin
        drain();
        write_enable(plan[i].enable);
      end
      drive_item(plan[i].c, plan[i].typed, plan[i].want);
    end

    // Each phase starts from an idle block, so the sender waits for every
    // outstanding result before the register is rewritten.
    phase = 0;
    while (counted < ITEM_TARGET) begin
      mode = phase % 4;
      drain();
      write_enable(mode != PH_MUTED);
      gappy = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(1, 12);
      case (mode)
        PH_FLOOD: n_items = $urandom_range(260, 540);
        PH_READOUT: n_items = $urandom_range(30, 90);
        default: n_items = $urandom_range(40, 120);
      endcase
      for (int unsigned k = 0; k < n_items && counted < ITEM_TARGET; k++) begin
        case (mode)
          // A long run of records may lap the reader; the fetches at the end
          // then see the drop total grow.
          PH_FLOOD: c = (k + 20 < n_items) ? random_cmd(100, 0) : random_cmd(0, 100);
          PH_READOUT: c = random_cmd(25, 70);
          default: c = random_cmd(55, 35);
        endcase
        drive_item(c, 0, none);
        if (gappy) begin
          burst_left--;
          if (burst_left == 0) begin
            idle($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
          end
        end
      end
      phase++;
    end

    drain();
    repeat (5) @(negedge clk);
    if (mismatches == 0)
      $display("overwriting_trace_ring_tb: PASS");
    else
      $display("overwriting_trace_ring_tb: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/otr_pkg.sv
hw/rtl/otr_store.sv
hw/rtl/otr_ctrl.sv
hw/rtl/overwriting_trace_ring.sv
sim/overwriting_trace_ring_tb.sv
